// ----- sv/csvs_pkg.sv -----
// Shared types and constants for the CSV row field splitter.
`default_nettype none

package csvs_pkg;

  // Byte that opens and closes a quoted section
  localparam logic [7:0] QUOTE_BYTE = 8'h22;

  // Delimiter after reset: comma
  localparam logic [7:0] DELIM_RESET = 8'h2c;

  // Result kind codes
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // One classified input item waiting for the back end
  typedef struct packed {
    logic       has_byte;   // byte result present (character or field end)
    logic       byte_kind;  // kind of the byte result
    logic [7:0] byte_char;  // byte passed through when byte_kind is a character
    logic       has_end;    // row-closing field end follows
  } entry_t;

endpackage

`default_nettype wire

// ----- sv/csvs_front.sv -----
// Front end: accept input bytes, track quote state and classify each item.
`default_nettype none

module csvs_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wen,
  input  wire logic [7:0]         cfg_wdata,
  input  wire logic               push,
  input  wire logic               full,
  input  wire logic [7:0]         char_in,
  input  wire logic               has_char,
  input  wire logic               row_end,
  output logic                    wr_en,
  output csvs_pkg::entry_t        wr_entry
);

  logic [7:0] delimiter;
  logic       in_quotes;
  logic       quote_pending;
  logic       in_quotes_next;
  logic       quote_pending_next;
  logic       accept;
  logic       is_quote;
  logic       is_delim;
  logic       doubled;
  logic       quoted_text;

  // Hold the delimiter register
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= csvs_pkg::DELIM_RESET;
    end else if (cfg_wen) begin
      delimiter <= cfg_wdata;
    end
  end

  assign accept      = push && !full;
  assign is_quote    = (char_in == csvs_pkg::QUOTE_BYTE);
  assign is_delim    = (char_in == delimiter);
  // Pending quote followed by a quote: the pair stays inside the section
  assign doubled     = in_quotes && quote_pending && is_quote;
  // Byte handled as quoted text (a pending quote with another byte closes first)
  assign quoted_text = in_quotes && !quote_pending;

  // Classify the byte and work out the next quote state
  always_comb begin
    in_quotes_next     = in_quotes;
    quote_pending_next = quote_pending;
    wr_entry.has_byte  = has_char;
    wr_entry.byte_kind = csvs_pkg::KIND_CHAR;
    wr_entry.byte_char = char_in;
    wr_entry.has_end   = row_end;
    if (has_char) begin
      if (doubled) begin
        quote_pending_next = 1'b0;
      end else if (quoted_text) begin
        quote_pending_next = is_quote;
      end else begin
        quote_pending_next = 1'b0;
        if (is_delim) begin
          in_quotes_next     = 1'b0;
          wr_entry.byte_kind = csvs_pkg::KIND_END;
          wr_entry.byte_char = 8'h00;
        end else begin
          in_quotes_next = is_quote;
        end
      end
    end
    if (row_end) begin
      in_quotes_next     = 1'b0;
      quote_pending_next = 1'b0;
    end
  end

  // Drop idle items; queue every item that causes a result
  assign wr_en = accept && (has_char || row_end);

  // Advance quote state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes     <= 1'b0;
      quote_pending <= 1'b0;
    end else if (accept) begin
      in_quotes     <= in_quotes_next;
      quote_pending <= quote_pending_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/csvs_fifo.sv -----
// Short queue of classified items between front and back end.
`default_nettype none

module csvs_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire csvs_pkg::entry_t   wr_entry,
  input  wire logic               rd_en,
  output csvs_pkg::entry_t        rd_entry,
  output logic                    full,
  output logic                    empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  csvs_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && !empty;
  assign rd_entry = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/csvs_back.sv -----
// Back end: expand queued items into one or two results in an output register.
`default_nettype none

module csvs_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire csvs_pkg::entry_t   rd_entry,
  input  wire logic               q_empty,
  output logic                    rd_en,
  input  wire logic               pop,
  output logic                    empty,
  output logic                    kind,
  output logic [7:0]              char_out,
  output logic                    row_done,
  output logic                    last
);

  logic out_valid;
  logic second;       // byte result of head entry already sent
  logic load;
  logic send_byte;

  assign empty     = !out_valid;
  assign load      = !out_valid || pop;
  assign send_byte = !second && rd_entry.has_byte;
  // Release the head entry once its final result is loaded
  assign rd_en     = load && !q_empty && !(send_byte && rd_entry.has_end);

  // Track which result of the head entry comes next
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        second <= send_byte && rd_entry.has_end;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      if (send_byte) begin
        kind     <= rd_entry.byte_kind;
        char_out <= rd_entry.byte_char;
        row_done <= 1'b0;
        last     <= !rd_entry.has_end;
      end else begin
        kind     <= csvs_pkg::KIND_END;
        char_out <= 8'h00;
        row_done <= 1'b1;
        last     <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/csv_row_field_splitter.sv -----
// Top level of the CSV row field splitter: front end, item queue, back end.
// An accepted byte is written to the queue, then loaded into the back end output register.
// Throughput: one input item per cycle while the queue is not full; an item with a byte
//   and a row end yields two results, sent one after the other by the back end output register.
// The queue of QUEUE_DEPTH entries lets front and back end stall apart.
// Reset (rst, synchronous): clears quote state, queue and the output valid flag,
//   and sets the delimiter to a comma.
`default_nettype none

module csv_row_field_splitter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wen,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] char_in,
  input  wire logic       has_char,
  input  wire logic       row_end,
  input  wire logic       pop,
  output logic            empty,
  output logic            kind,
  output logic [7:0]      char_out,
  output logic            row_done,
  output logic            last
);

  csvs_pkg::entry_t wr_entry;
  csvs_pkg::entry_t rd_entry;
  logic             wr_en;
  logic             rd_en;
  logic             q_empty;

  csvs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .full      (full),
    .char_in   (char_in),
    .has_char  (has_char),
    .row_end   (row_end),
    .wr_en     (wr_en),
    .wr_entry  (wr_entry)
  );

  csvs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_entry (rd_entry),
    .full     (full),
    .empty    (q_empty)
  );

  csvs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_entry (rd_entry),
    .q_empty  (q_empty),
    .rd_en    (rd_en),
    .pop      (pop),
    .empty    (empty),
    .kind     (kind),
    .char_out (char_out),
    .row_done (row_done),
    .last     (last)
  );

`ifndef SYNTHESIS
  // Row close is always a field end and the final result of its transaction
  a_row_done_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && row_done) |-> (kind == csvs_pkg::KIND_END) && last)
    else $error("row_done without final field end");

  // A field end carries no character
  a_end_no_char: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == csvs_pkg::KIND_END) |-> (char_out == 8'h00))
    else $error("field end with nonzero char_out");

  // The queue fills only after an accepted transaction
  a_full_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("queue filled without an input transaction");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_csv_row_field_splitter.sv -----
// Self-checking testbench for the CSV row field splitter: random and directed rows.
`timescale 1ns / 1ps

module tb_csv_row_field_splitter;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int PHASE_ITEMS    = 100;

  // One input transaction
  typedef struct {
    logic [7:0] ch;
    logic       has;
    logic       rend;
  } row_item_t;

  // One output transaction
  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       done;
    logic       last;
  } split_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wen = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       push = 1'b0;
  logic [7:0] char_in = 8'h00;
  logic       has_char = 1'b0;
  logic       row_end = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic       kind;
  logic [7:0] char_out;
  logic       row_done;
  logic       last;

  row_item_t     byte_items_q[$];
  split_result_t split_due_q[$];

  // Predictor state
  logic [7:0] delim_sel = csvs_pkg::DELIM_RESET;
  logic       in_quote = 1'b0;
  logic       quote_wait = 1'b0;

  int err_cnt = 0;

  csv_row_field_splitter uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .push     (push),
    .full     (full),
    .char_in  (char_in),
    .has_char (has_char),
    .row_end  (row_end),
    .pop      (pop),
    .empty    (empty),
    .kind     (kind),
    .char_out (char_out),
    .row_done (row_done),
    .last     (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic split_result_t mk_result(logic k, logic [7:0] c, logic d);
    split_result_t r;
    r.kind = k;
    r.ch   = c;
    r.done = d;
    r.last = 1'b0;
    return r;
  endfunction

  // Advance the quote state for one accepted transaction and queue its results
  function automatic void split_item(logic [7:0] c, logic has, logic rend);
    split_result_t res[$];
    logic handled;
    handled = 1'b0;
    if (has) begin
      // Resolve a pending quote: doubled quote or close of the section
      if (in_quote && quote_wait) begin
        quote_wait = 1'b0;
        if (c == csvs_pkg::QUOTE_BYTE) begin
          res = {res, mk_result(csvs_pkg::KIND_CHAR, c, 1'b0)};
          handled = 1'b1;
        end else begin
          in_quote = 1'b0;
        end
      end
      if (!handled) begin
        if (in_quote) begin
          res = {res, mk_result(csvs_pkg::KIND_CHAR, c, 1'b0)};
          if (c == csvs_pkg::QUOTE_BYTE) quote_wait = 1'b1;
        end else if (c == delim_sel) begin
          res = {res, mk_result(csvs_pkg::KIND_END, 8'h00, 1'b0)};
        end else begin
          res = {res, mk_result(csvs_pkg::KIND_CHAR, c, 1'b0)};
          if (c == csvs_pkg::QUOTE_BYTE) in_quote = 1'b1;
        end
      end
    end
    // Row end closes the field and drops all quote state
    if (rend) begin
      res = {res, mk_result(csvs_pkg::KIND_END, 8'h00, 1'b1)};
      in_quote = 1'b0;
      quote_wait = 1'b0;
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) split_due_q = {split_due_q, res[i]};
  endfunction

  // Driver: bursts of transactions with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : drive_proc
    row_item_t it;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) split_item(char_in, has_char, row_end);
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          push <= 1'b0;
        end else if (byte_items_q.size() > 0) begin
          it = byte_items_q.pop_front();
          push <= 1'b1;
          char_in <= it.ch;
          has_char <= it.has;
          row_end <= it.rend;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: receiver stalls follow a mode that changes every so often
  int         pop_mode = 0;
  int         mode_left = 0;
  logic [15:0] pop_pattern = 16'hffff;

  always @(posedge clk) begin : monitor_proc
    split_result_t exp_r;
    logic next_pop;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      // Check the transaction taken at this edge
      if (pop && !empty) begin
        if (split_due_q.size() == 0) begin
          $error("unexpected result: kind %0d char_out %02h row_done %0d last %0d",
                 kind, char_out, row_done, last);
          err_cnt++;
        end else begin
          exp_r = split_due_q.pop_front();
          if (kind !== exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, kind);
            err_cnt++;
          end
          if (char_out !== exp_r.ch) begin
            $error("char_out: expected %02h, got %02h", exp_r.ch, char_out);
            err_cnt++;
          end
          if (row_done !== exp_r.done) begin
            $error("row_done: expected %0d, got %0d", exp_r.done, row_done);
            err_cnt++;
          end
          if (last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, last);
            err_cnt++;
          end
        end
      end
      // Pick the next stall mode
      if (mode_left == 0) begin
        pop_mode = $urandom_range(0, 3);
        pop_pattern = 16'($urandom);
        mode_left = $urandom_range(8, 80);
      end else begin
        mode_left = mode_left - 1;
      end
      case (pop_mode)
        0: begin
          next_pop = 1'b1;
        end
        1: begin
          next_pop = 1'($urandom_range(0, 1));
        end
        2: begin
          next_pop = pop_pattern[0];
          pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
        end
        default: begin
          next_pop = ($urandom_range(0, 7) == 0);
        end
      endcase
      pop <= next_pop;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic add_item(logic [7:0] c, logic has, logic rend);
    row_item_t it;
    it.ch = c;
    it.has = has;
    it.rend = rend;
    byte_items_q = {byte_items_q, it};
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == csvs_pkg::QUOTE_BYTE || b == delim_sel) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Build one row of fields: plain, well-formed quoted, or noise
  task automatic add_row(output int cnt);
    logic [7:0] row_bytes[$];
    int nf;
    int ft;
    int len;
    int sel;
    logic end_on_byte;
    nf = $urandom_range(1, 6);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) row_bytes = {row_bytes, delim_sel};
      ft = $urandom_range(0, 5);
      len = $urandom_range(0, 5);
      if (ft <= 2) begin
        for (int i = 0; i < len; i++) row_bytes = {row_bytes, plain_byte()};
      end else if (ft <= 4) begin
        row_bytes = {row_bytes, csvs_pkg::QUOTE_BYTE};
        for (int i = 0; i < len; i++) begin
          sel = $urandom_range(0, 5);
          if (sel == 0) begin
            row_bytes = {row_bytes, csvs_pkg::QUOTE_BYTE, csvs_pkg::QUOTE_BYTE};
          end else if (sel == 1 && delim_sel != csvs_pkg::QUOTE_BYTE) begin
            row_bytes = {row_bytes, delim_sel};
          end else begin
            row_bytes = {row_bytes, plain_byte()};
          end
        end
        row_bytes = {row_bytes, csvs_pkg::QUOTE_BYTE};
      end else begin
        for (int i = 0; i <= len; i++) begin
          sel = $urandom_range(0, 3);
          if (sel == 0) row_bytes = {row_bytes, csvs_pkg::QUOTE_BYTE};
          else if (sel == 1) row_bytes = {row_bytes, delim_sel};
          else row_bytes = {row_bytes, 8'($urandom_range(0, 255))};
        end
      end
    end
    end_on_byte = (row_bytes.size() > 0) && ($urandom_range(0, 3) != 0);
    cnt = 0;
    foreach (row_bytes[i]) begin
      // Drop in an idle transaction now and then
      if ($urandom_range(0, 15) == 0) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      add_item(row_bytes[i], 1'b1, end_on_byte && (i == row_bytes.size() - 1));
      cnt++;
    end
    if (!end_on_byte) begin
      add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      cnt++;
    end
  endtask

  task automatic add_rows(int n);
    int added;
    int cnt;
    added = 0;
    while (added < n) begin
      add_row(cnt);
      added += cnt;
    end
  endtask

  // Hold until no transaction is queued, in flight, or expected
  task automatic wait_drained();
    @(negedge clk);
    while (byte_items_q.size() != 0 || push || split_due_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_delim(logic [7:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    delim_sel = v;
  endtask

  initial begin : stim_proc
    logic [7:0] phase_delims[$];
    phase_delims = '{8'h00, 8'hff, 8'h2c, 8'h09,
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: comma delimiter, quote handling corner cases
    set_delim(csvs_pkg::DELIM_RESET);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'h2c, 1'b1, 1'b0);
    add_item(8'hff, 1'b1, 1'b0);
    add_item(csvs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    add_item(8'h2c, 1'b1, 1'b0);      // delimiter inside quotes is text
    add_item(csvs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    add_item(csvs_pkg::QUOTE_BYTE, 1'b1, 1'b0); // doubled quote stays inside
    add_item(8'h41, 1'b1, 1'b0);
    add_item(csvs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    add_item(8'h2c, 1'b1, 1'b0);      // close, then end the field
    add_item(csvs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    add_item(csvs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    add_item(8'h62, 1'b1, 1'b0);      // close, then plain byte
    add_item(8'h00, 1'b0, 1'b1);      // bare row end
    add_item(8'h5a, 1'b0, 1'b0);      // idle
    add_item(csvs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    add_item(8'h71, 1'b1, 1'b1);      // unclosed quotes at row end
    add_item(csvs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    add_item(csvs_pkg::QUOTE_BYTE, 1'b1, 1'b1); // quote at row end
    add_item(csvs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    add_item(csvs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    add_item(8'h7f, 1'b1, 1'b1);
    add_item(csvs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    add_item(csvs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    add_item(8'hff, 1'b0, 1'b1);      // pending quote at bare row end

    // Delimiter equal to the quote byte
    set_delim(csvs_pkg::QUOTE_BYTE);
    add_item(csvs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    add_item(8'h2c, 1'b1, 1'b0);
    add_item(csvs_pkg::QUOTE_BYTE, 1'b1, 1'b1);
    add_rows(PHASE_ITEMS / 2);
    wait_drained();
    add_rows(PHASE_ITEMS / 2);

    // Random rows under a range of delimiters, pausing halfway in each
    foreach (phase_delims[p]) begin
      set_delim(phase_delims[p]);
      add_rows(PHASE_ITEMS / 2);
      wait_drained();
      add_rows(PHASE_ITEMS / 2);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0 && split_due_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/csvs_pkg.sv
sv/csvs_front.sv
sv/csvs_fifo.sv
sv/csvs_back.sv
sv/csv_row_field_splitter.sv
tb/tb_csv_row_field_splitter.sv
